// ===== rtl/core/jet_pkg.sv =====
package jet_pkg;

  // Fixed-point format of z and c
  localparam int ZW         = 32;
  localparam int FRAC_BITS  = 28;
  localparam int COUNT_BITS = 10;
  localparam int PROD_W     = 2 * ZW;
  // Wide enough for a shifted product plus c without wrap
  localparam int SUM_W      = ZW + 8;
  localparam int BAIL_W     = 33;
  localparam int CFG_W      = BAIL_W;

  localparam logic [COUNT_BITS-1:0] MAX_ITER_RESET = COUNT_BITS'(50);
  localparam logic [BAIL_W-1:0]     BAILOUT_RESET  = BAIL_W'(64'd1073741824);

  typedef logic signed [ZW-1:0]     z_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [COUNT_BITS-1:0]    cnt_t;
  typedef logic [BAIL_W-1:0]        bail_t;
  typedef logic [CFG_W-1:0]         cfg_data_t;

  typedef enum logic [1:0] {
    CFG_C_REAL     = 2'd0,
    CFG_C_IMAG     = 2'd1,
    CFG_BAILOUT_SQ = 2'd2,
    CFG_MAX_ITER   = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_RR,
    ST_MUL_II,
    ST_MUL_RI,
    ST_UPDATE,
    ST_CHECK,
    ST_MAG_IM,
    ST_COMPARE,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/core/jet_in_if.sv =====
interface jet_in_if;
  import jet_pkg::*;

  logic valid;
  logic ready;
  z_t   start_real;
  z_t   start_imag;

  modport source (output valid, output start_real, output start_imag, input ready);
  modport sink   (input valid, input start_real, input start_imag, output ready);
endinterface

// ===== rtl/core/jet_out_if.sv =====
interface jet_out_if;
  import jet_pkg::*;

  logic valid;
  logic ready;
  cnt_t iter_count;

  modport source (output valid, output iter_count, input ready);
  modport sink   (input valid, input iter_count, output ready);
endinterface

// ===== rtl/core/julia_escape_time.sv =====
// Channel   Dir  Payload                   Handshake
// point     in   start_real, start_imag    valid/ready
// result    out  iter_count                valid/ready
// cfg       in   cfg_index, cfg_data       cfg_we, no stall
//
// One step runs MUL_RR, MUL_II, MUL_RI, UPDATE, CHECK, MAG_IM and COMPARE
// on one shared 32x32 multiplier (five products, then the add/compare of
// |z|^2); a step that overflows a component ends after CHECK instead.
// Reset (rst, synchronous) loads c = 0, bailout_sq = 4.0, max_iter = 50.
// A finished result sits in an output register; the next point is
// accepted while it waits, and only the final write stalls on result.ready.
module julia_escape_time (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  jet_pkg::cfg_idx_t   cfg_index,
  input  jet_pkg::cfg_data_t  cfg_data,
  jet_in_if.sink              point,
  jet_out_if.source           result
);
  import jet_pkg::*;

  // Configuration registers
  z_t    c_real;
  z_t    c_imag;
  bail_t bailout_sq;
  cnt_t  max_iter;

  // Sequencer and datapath
  state_t state;
  state_t state_next;
  z_t     re;
  z_t     im;
  z_t     nre;
  z_t     nim;
  logic   z_ovf;
  prod_t  acc;
  prod_t  prod;
  cnt_t   iter;
  cnt_t   limit;
  cnt_t   count;
  z_t     mul_a;
  z_t     mul_b;
  logic   out_load;
  logic   out_valid;
  cnt_t   out_count;

  prod_t  re_shr;
  prod_t  im_shr;
  sum_t   nre_sum;
  sum_t   nim_sum;
  logic   sum_ovf;
  logic [PROD_W-1:0]           mag;
  logic [PROD_W-FRAC_BITS-1:0] mag_hi;
  logic                        escape;
  logic                        last_step;
  logic                        accept;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      c_real     <= '0;
      c_imag     <= '0;
      bailout_sq <= BAILOUT_RESET;
      max_iter   <= MAX_ITER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_C_REAL:     c_real     <= cfg_data[ZW-1:0];
        CFG_C_IMAG:     c_imag     <= cfg_data[ZW-1:0];
        CFG_BAILOUT_SQ: bailout_sq <= cfg_data[BAIL_W-1:0];
        CFG_MAX_ITER:   max_iter   <= cfg_data[COUNT_BITS-1:0];
      endcase
    end
  end

  jet_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Step arithmetic: floor shifts, add c, range test, |z|^2 compare
  assign re_shr    = acc >>> FRAC_BITS;
  assign im_shr    = prod >>> (FRAC_BITS - 1);
  assign nre_sum   = sum_t'(re_shr[SUM_W-1:0]) + SUM_W'(c_real);
  assign nim_sum   = sum_t'(im_shr[SUM_W-1:0]) + SUM_W'(c_imag);
  assign sum_ovf   = ((nre_sum[SUM_W-1:ZW-1] != '0) && (nre_sum[SUM_W-1:ZW-1] != '1)) ||
                     ((nim_sum[SUM_W-1:ZW-1] != '0) && (nim_sum[SUM_W-1:ZW-1] != '1));
  assign mag       = unsigned'(acc) + unsigned'(prod);
  assign mag_hi    = mag[PROD_W-1:FRAC_BITS];
  assign escape    = (mag_hi > (PROD_W-FRAC_BITS)'(bailout_sq)) ||
                     ((mag_hi == (PROD_W-FRAC_BITS)'(bailout_sq)) &&
                      (mag[FRAC_BITS-1:0] != '0));
  assign last_step = (iter == limit - cnt_t'(1));
  assign accept    = point.valid && point.ready;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance the sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (point.valid) begin
          state_next = (max_iter == '0) ? ST_FINISH : ST_MUL_RR;
        end
      end
      ST_MUL_RR:  state_next = ST_MUL_II;
      ST_MUL_II:  state_next = ST_MUL_RI;
      ST_MUL_RI:  state_next = ST_UPDATE;
      ST_UPDATE:  state_next = ST_CHECK;
      ST_CHECK:   state_next = z_ovf ? ST_FINISH : ST_MAG_IM;
      ST_MAG_IM:  state_next = ST_COMPARE;
      ST_COMPARE: state_next = (escape || last_step) ? ST_FINISH : ST_MUL_RR;
      ST_FINISH: begin
        if (!out_valid || result.ready) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // Drive handshake and multiplier operands
  always_comb begin
    point.ready = 1'b0;
    out_load    = 1'b0;
    mul_a       = re;
    mul_b       = re;
    unique case (state)
      ST_IDLE:   point.ready = 1'b1;
      ST_MUL_II: begin
        mul_a = im;
        mul_b = im;
      end
      ST_MUL_RI: begin
        mul_a = re;
        mul_b = im;
      end
      ST_CHECK: begin
        mul_a = nre;
        mul_b = nre;
      end
      ST_MAG_IM: begin
        mul_a = nim;
        mul_b = nim;
      end
      ST_FINISH: out_load = !out_valid || result.ready;
      default: ;
    endcase
  end

  // Update datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          re    <= point.start_real;
          im    <= point.start_imag;
          iter  <= '0;
          limit <= max_iter;
          count <= '0;
        end
      end
      ST_MUL_II: acc <= prod;
      ST_MUL_RI: acc <= acc - prod;
      ST_UPDATE: begin
        nre   <= nre_sum[ZW-1:0];
        nim   <= nim_sum[ZW-1:0];
        z_ovf <= sum_ovf;
      end
      ST_CHECK: begin
        if (z_ovf) begin
          count <= iter;
        end
      end
      ST_MAG_IM: acc <= prod;
      ST_COMPARE: begin
        if (escape) begin
          count <= iter;
        end else begin
          re   <= nre;
          im   <= nim;
          iter <= iter + cnt_t'(1);
        end
      end
      default: ;
    endcase
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count <= count;
    end
  end

  assign result.valid      = out_valid;
  assign result.iter_count = out_count;

endmodule

// ===== rtl/core/jet_mul.sv =====
module jet_mul (
  input  logic        clk,
  input  jet_pkg::z_t a,
  input  jet_pkg::z_t b,
  output jet_pkg::prod_t prod
);
  import jet_pkg::*;

  // Register the signed product every cycle
  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule
